FILE: rtl/core/lsrc_pkg.sv
// Package for the line segment rectangle clipper.
// Holds the shared types, edge codes and register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsrc_pkg;

    localparam int COORD_W = 16;
    localparam int QUO_W   = 32;   // magnitude of delta * distance fits 32 bits

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_HI   = 2'd1,          // right or bottom edge
        EDGE_LO   = 2'd2           // left or top edge
    } lsrc_edge_t;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_TOP    = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } lsrc_win_t;

    // One clip request: fixed point, moving point and control flags.
    typedef struct packed {
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic                      act;   // clip the moving point
        logic                      vis;   // visible so far
        logic                      tag;   // carried along untouched
    } lsrc_clip_t;

    // Bundle that travels through the divider stages.
    typedef struct packed {
        lsrc_clip_t          item;
        lsrc_edge_t          vert;
        lsrc_edge_t          horz;
        logic                zv;
        logic                zh;
        logic                sv;
        logic                sh;
        logic [COORD_W-1:0]  rv;
        logic [COORD_W-1:0]  rh;
        logic [QUO_W-1:0]    nv;
        logic [QUO_W-1:0]    nh;
        logic [COORD_W-1:0]  dv;
        logic [COORD_W-1:0]  dh;
    } lsrc_dv_t;

endpackage

`default_nettype wire

FILE: rtl/core/lsrc_clip_point.sv
// Pipelined clip of one moving point toward a fixed point.
// Depends on lsrc_pkg; two restoring dividers run one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lsrc_clip_point (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 en,
    input  wire                 in_vld,
    input  lsrc_pkg::lsrc_clip_t in_item,
    input  lsrc_pkg::lsrc_win_t  win,
    output logic                out_vld,
    output lsrc_pkg::lsrc_clip_t out_item
);

    localparam int NSTG = lsrc_pkg::QUO_W;

    // Stage A: deltas, edge codes and distances to the edges.
    typedef struct packed {
        lsrc_pkg::lsrc_clip_t item;
        lsrc_pkg::lsrc_edge_t vert;
        lsrc_pkg::lsrc_edge_t horz;
        logic signed [16:0]   dx;
        logic signed [16:0]   dy;
        logic signed [16:0]   bv;
        logic signed [16:0]   bh;
    } lsrc_sa_t;

    typedef struct packed {
        lsrc_pkg::lsrc_clip_t item;
        lsrc_pkg::lsrc_edge_t vert;
        lsrc_pkg::lsrc_edge_t horz;
        logic signed [16:0]   dx;
        logic signed [16:0]   dy;
        logic signed [33:0]   pv;
        logic signed [33:0]   ph;
    } lsrc_sb_t;

    lsrc_sa_t sa_reg, sa_next;
    logic     sa_vld_reg;
    lsrc_sb_t sb_reg, sb_next;
    logic     sb_vld_reg;
    lsrc_pkg::lsrc_dv_t dv_reg [0:NSTG];
    lsrc_pkg::lsrc_dv_t dv_next [0:NSTG];
    logic               dv_vld_reg [0:NSTG];
    lsrc_pkg::lsrc_clip_t out_item_reg, out_item_next;
    logic                 out_vld_reg;

    logic signed [16:0] fx_e, fy_e, mx_e, my_e;
    logic signed [16:0] l_e, t_e, r_e, b_e;

    assign fx_e = {in_item.fx[15], in_item.fx};
    assign fy_e = {in_item.fy[15], in_item.fy};
    assign mx_e = {in_item.mx[15], in_item.mx};
    assign my_e = {in_item.my[15], in_item.my};
    assign l_e  = {win.left[15], win.left};
    assign t_e  = {win.top[15], win.top};
    assign r_e  = {win.right[15], win.right};
    assign b_e  = {win.bottom[15], win.bottom};

    always_comb
    begin
        sa_next      = '0;
        sa_next.item = in_item;
        sa_next.dx   = mx_e - fx_e;
        sa_next.dy   = my_e - fy_e;
        if (in_item.mx > win.right)
        begin
            sa_next.vert = lsrc_pkg::EDGE_HI;
            sa_next.bv   = r_e - fx_e;
        end
        else if (in_item.mx < win.left)
        begin
            sa_next.vert = lsrc_pkg::EDGE_LO;
            sa_next.bv   = l_e - fx_e;
        end
        else
        begin
            sa_next.vert = lsrc_pkg::EDGE_NONE;
            sa_next.bv   = '0;
        end
        if (in_item.my > win.bottom)
        begin
            sa_next.horz = lsrc_pkg::EDGE_HI;
            sa_next.bh   = b_e - fy_e;
        end
        else if (in_item.my < win.top)
        begin
            sa_next.horz = lsrc_pkg::EDGE_LO;
            sa_next.bh   = t_e - fy_e;
        end
        else
        begin
            sa_next.horz = lsrc_pkg::EDGE_NONE;
            sa_next.bh   = '0;
        end
        if (!in_item.act)
        begin
            sa_next.vert = lsrc_pkg::EDGE_NONE;
            sa_next.horz = lsrc_pkg::EDGE_NONE;
        end
    end

    // Stage B: one 17 x 17 signed product per edge.
    always_comb
    begin
        sb_next.item = sa_reg.item;
        sb_next.vert = sa_reg.vert;
        sb_next.horz = sa_reg.horz;
        sb_next.dx   = sa_reg.dx;
        sb_next.dy   = sa_reg.dy;
        sb_next.pv   = sa_reg.dy * sa_reg.bv;
        sb_next.ph   = sa_reg.dx * sa_reg.bh;
    end

    // Stage C: magnitudes and quotient signs feed the dividers.
    always_comb
    begin
        logic signed [33:0] npv, nph;
        logic signed [16:0] ndx, ndy;
        npv = -sb_reg.pv;
        nph = -sb_reg.ph;
        ndx = -sb_reg.dx;
        ndy = -sb_reg.dy;
        dv_next[0]      = '0;
        dv_next[0].item = sb_reg.item;
        dv_next[0].vert = sb_reg.vert;
        dv_next[0].horz = sb_reg.horz;
        dv_next[0].zv   = (sb_reg.dx == '0);
        dv_next[0].zh   = (sb_reg.dy == '0);
        dv_next[0].sv   = sb_reg.pv[33] ^ sb_reg.dx[16];
        dv_next[0].sh   = sb_reg.ph[33] ^ sb_reg.dy[16];
        dv_next[0].nv   = sb_reg.pv[33] ? npv[31:0] : sb_reg.pv[31:0];
        dv_next[0].nh   = sb_reg.ph[33] ? nph[31:0] : sb_reg.ph[31:0];
        dv_next[0].dv   = sb_reg.dx[16] ? ndx[15:0] : sb_reg.dx[15:0];
        dv_next[0].dh   = sb_reg.dy[16] ? ndy[15:0] : sb_reg.dy[15:0];
    end

    // Restoring division, one quotient bit per stage; the dividend register
    // shifts left and fills up with quotient bits.
    for (genvar k = 0; k < NSTG; k++)
    begin : g_div
        always_comb
        begin
            logic [16:0] tv, th;
            tv = {dv_reg[k].rv, dv_reg[k].nv[NSTG-1]};
            th = {dv_reg[k].rh, dv_reg[k].nh[NSTG-1]};
            dv_next[k+1] = dv_reg[k];
            if (tv >= {1'b0, dv_reg[k].dv})
            begin
                dv_next[k+1].rv = 16'(tv - {1'b0, dv_reg[k].dv});
                dv_next[k+1].nv = {dv_reg[k].nv[NSTG-2:0], 1'b1};
            end
            else
            begin
                dv_next[k+1].rv = tv[15:0];
                dv_next[k+1].nv = {dv_reg[k].nv[NSTG-2:0], 1'b0};
            end
            if (th >= {1'b0, dv_reg[k].dh})
            begin
                dv_next[k+1].rh = 16'(th - {1'b0, dv_reg[k].dh});
                dv_next[k+1].nh = {dv_reg[k].nh[NSTG-2:0], 1'b1};
            end
            else
            begin
                dv_next[k+1].rh = th[15:0];
                dv_next[k+1].nh = {dv_reg[k].nh[NSTG-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k+1] <= 1'b0;
            else if (en)
                dv_vld_reg[k+1] <= dv_vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k+1] <= dv_next[k+1];
        end
    end

    // Final stage: signed quotient, intersection, range test and selection.
    always_comb
    begin
        lsrc_pkg::lsrc_dv_t d;
        logic signed [32:0] qv, qh;
        logic signed [33:0] yi, xi;
        logic signed [33:0] lw, tw, rw, bw;
        logic               okv, okh;
        d  = dv_reg[NSTG];
        qv = d.sv ? -$signed({1'b0, d.nv}) : $signed({1'b0, d.nv});
        qh = d.sh ? -$signed({1'b0, d.nh}) : $signed({1'b0, d.nh});
        yi = d.zv ? -34'sd1 : $signed({{18{d.item.fy[15]}}, d.item.fy}) + $signed({qv[32], qv});
        xi = d.zh ? -34'sd1 : $signed({{18{d.item.fx[15]}}, d.item.fx}) + $signed({qh[32], qh});
        lw = {{18{win.left[15]}}, win.left};
        tw = {{18{win.top[15]}}, win.top};
        rw = {{18{win.right[15]}}, win.right};
        bw = {{18{win.bottom[15]}}, win.bottom};
        okv = (d.vert != lsrc_pkg::EDGE_NONE) && (yi >= tw) && (yi <= bw);
        okh = (d.horz != lsrc_pkg::EDGE_NONE) && (xi >= lw) && (xi <= rw);
        out_item_next = d.item;
        if (okh)
        begin
            out_item_next.mx = xi[15:0];
            out_item_next.my = (d.horz == lsrc_pkg::EDGE_HI) ? win.bottom : win.top;
        end
        else if (okv)
        begin
            out_item_next.mx = (d.vert == lsrc_pkg::EDGE_HI) ? win.right : win.left;
            out_item_next.my = yi[15:0];
        end
        out_item_next.vis = d.item.vis | okv | okh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg    <= 1'b0;
            sb_vld_reg    <= 1'b0;
            dv_vld_reg[0] <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else if (en)
        begin
            sa_vld_reg    <= in_vld;
            sb_vld_reg    <= sa_vld_reg;
            dv_vld_reg[0] <= sb_vld_reg;
            out_vld_reg   <= dv_vld_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg       <= sa_next;
            sb_reg       <= sb_next;
            dv_reg[0]    <= dv_next[0];
            out_item_reg <= out_item_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_item = out_item_reg;

endmodule

`default_nettype wire

FILE: rtl/core/line_segment_rect_clip_top.sv
// Top level of the line segment rectangle clipper: window registers,
// classification stage and two chained point clippers (lsrc_clip_point, lsrc_pkg).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       start_x, start_y, end_x, end_y
// m_*       out        m_tvalid / m_tready       visible and the clipped points
// APB       in/out     psel, penable, pready     clip_left, clip_top, clip_right, clip_bottom
//
// One request enters per cycle unless the output stalls; it passes through
// a classification stage, then two point clippers of 36 stages each, whose
// length is set by the 32 stages of the bit-per-stage restoring dividers.
// Reset clears every valid bit and loads the default 320 x 200 window.
// All stages advance together whenever the output register is empty or
// being read, so a stall freezes the pipeline without losing a request.
module line_segment_rect_clip_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y
    input  wire  [63:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] visible, [16:1] clipped_start_x, [32:17] clipped_start_y,
    // [48:33] clipped_end_x, [64:49] clipped_end_y, [71:65] zero
    output logic [71:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lsrc_pkg::lsrc_win_t win_reg;
    logic                pipe_en;
    logic                wr_en;

    // The four window registers sit at byte addresses 0, 4, 8 and 12.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.left   <= 16'sd0;
            win_reg.top    <= 16'sd0;
            win_reg.right  <= 16'sd319;
            win_reg.bottom <= 16'sd199;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                lsrc_pkg::REG_LEFT:   win_reg.left   <= pwdata[15:0];
                lsrc_pkg::REG_TOP:    win_reg.top    <= pwdata[15:0];
                lsrc_pkg::REG_RIGHT:  win_reg.right  <= pwdata[15:0];
                lsrc_pkg::REG_BOTTOM: win_reg.bottom <= pwdata[15:0];
                default:              win_reg.left   <= win_reg.left;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lsrc_pkg::REG_LEFT:   prdata = {{16{win_reg.left[15]}}, win_reg.left};
            lsrc_pkg::REG_TOP:    prdata = {{16{win_reg.top[15]}}, win_reg.top};
            lsrc_pkg::REG_RIGHT:  prdata = {{16{win_reg.right[15]}}, win_reg.right};
            lsrc_pkg::REG_BOTTOM: prdata = {{16{win_reg.bottom[15]}}, win_reg.bottom};
            default:              prdata = '0;
        endcase
    end

    // Classification stage. Segments with both ends inside pass as visible,
    // segments fully beyond one edge are rejected; the rest are clipped.
    // The tag carries whether the second clipper moves the start point.
    lsrc_pkg::lsrc_clip_t cls_reg, cls_next;
    logic                 cls_vld_reg;

    always_comb
    begin
        logic signed [15:0] x1, y1, x2, y2;
        logic               in1, in2, rej, both_out;
        x1 = s_tdata[15:0];
        y1 = s_tdata[31:16];
        x2 = s_tdata[47:32];
        y2 = s_tdata[63:48];
        in1 = (x1 >= win_reg.left) && (x1 <= win_reg.right) &&
              (y1 >= win_reg.top) && (y1 <= win_reg.bottom);
        in2 = (x2 >= win_reg.left) && (x2 <= win_reg.right) &&
              (y2 >= win_reg.top) && (y2 <= win_reg.bottom);
        rej = ((x1 < win_reg.left) && (x2 < win_reg.left)) ||
              ((x1 > win_reg.right) && (x2 > win_reg.right)) ||
              ((y1 < win_reg.top) && (y2 < win_reg.top)) ||
              ((y1 > win_reg.bottom) && (y2 > win_reg.bottom));
        both_out = !in1 && !in2;
        cls_next.fx  = x1;
        cls_next.fy  = y1;
        cls_next.mx  = x2;
        cls_next.my  = y2;
        cls_next.vis = in1 && in2;
        if ((in1 && in2) || (both_out && rej))
        begin
            cls_next.act = 1'b0;
            cls_next.tag = 1'b0;
        end
        else
        begin
            cls_next.act = in1 || both_out;
            cls_next.tag = in2 || both_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cls_vld_reg <= 1'b0;
        else if (pipe_en)
            cls_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            cls_reg <= cls_next;
    end

    // First clipper moves the end point toward the start point.
    lsrc_pkg::lsrc_clip_t c1_out, c2_in, c2_out;
    logic                 c1_vld, c2_vld;

    lsrc_clip_point u_clip_end (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (cls_vld_reg),
        .in_item  (cls_reg),
        .win      (win_reg),
        .out_vld  (c1_vld),
        .out_item (c1_out)
    );

    // Second clipper moves the start point toward the possibly moved end point.
    always_comb
    begin
        c2_in.fx  = c1_out.mx;
        c2_in.fy  = c1_out.my;
        c2_in.mx  = c1_out.fx;
        c2_in.my  = c1_out.fy;
        c2_in.act = c1_out.tag;
        c2_in.vis = c1_out.vis;
        c2_in.tag = 1'b0;
    end

    lsrc_clip_point u_clip_start (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (c1_vld),
        .in_item  (c2_in),
        .win      (win_reg),
        .out_vld  (c2_vld),
        .out_item (c2_out)
    );

    // The clipper's last register is the output register.
    assign pipe_en  = !c2_vld || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = c2_vld;
    assign m_tdata  = {7'd0, c2_out.fy, c2_out.fx, c2_out.my, c2_out.mx, c2_out.vis};

    // The input side is blocked only while a result is held.
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("input blocked without a pending result");

    // A segment that passes whole is never clipped again.
    assert property (@(posedge clk) disable iff (!rst_n)
        cls_vld_reg && cls_reg.vis |-> !cls_reg.act && !cls_reg.tag)
        else $error("inside segment marked for clipping");

    // An accepted request shows up in the classification stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> cls_vld_reg)
        else $error("accepted request lost at classification");

endmodule

`default_nettype wire
